>>> sv/pic_pkg.sv
// Shared constants, types and request codes of the platform interrupt controller.
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    // Sizing. All sources fit in one 32-bit pending/enable word.
    localparam int NUM_SOURCES    = 32;
    localparam int NUM_CONTEXTS   = 2;
    localparam int PRIORITY_WIDTH = 3;

    localparam int ID_W  = $clog2(NUM_SOURCES);
    localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int IRQ_W = 2;

    // Request and result field widths
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 22;
    localparam int DATA_W    = 32;
    localparam int LINES_W   = 32;
    localparam int S_TDATA_W = 88;   // 22 + 32 + 32 = 86, padded to bytes
    localparam int M_TDATA_W = 40;   // 32 + 2 = 34, padded to bytes

    // Register window map
    localparam logic [ADDR_W-1:0] PEND_BASE = 22'h001000;
    localparam logic [ADDR_W-1:0] EN_BASE   = 22'h002000;
    localparam logic [ADDR_W-1:0] CTX_BASE  = 22'h200000;
    localparam logic [11:0]       THR_OFF   = 12'h000;
    localparam logic [11:0]       CLAIM_OFF = 12'h004;

    typedef logic [PRIORITY_WIDTH-1:0] pri_t;
    typedef logic [ID_W-1:0]           src_id_t;
    typedef logic [NUM_SOURCES-1:0]    src_vec_t;
    typedef logic [CTX_W-1:0]          ctx_idx_t;

    // Bits of existing sources; source 0 is reserved
    localparam src_vec_t SRC_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_IDLE   = 2'd3
    } op_t;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic capture;    // latch accepted request
        logic execute;    // perform access / gateway update
        logic arb_load;   // first arbitration stage
        logic finish;     // second arbitration stage and result load
    } pic_cmd_t;

endpackage

`default_nettype wire

>>> sv/pic_ctrl.sv
// Request sequencer: handshakes and per-request command sequence.
`timescale 1ns / 1ps
`default_nettype none

module pic_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output pic_pkg::pic_cmd_t cmd
);
    import pic_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_ARB  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;
    // no request is taken while reset is held
    assign s_ready  = aresetn && (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = ST_ARB;
            end
            ST_ARB: begin
                cmd.arb_load = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                // hold here while the previous result is still unread
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/pic_arb.sv
// Two-stage registered priority tree: best eligible source per context.
`timescale 1ns / 1ps
`default_nettype none

module pic_arb (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              stage1_en,
    input  logic              stage2_en,
    input  pic_pkg::src_vec_t pending,
    input  pic_pkg::src_vec_t enable    [pic_pkg::NUM_CONTEXTS],
    input  pic_pkg::pri_t     threshold [pic_pkg::NUM_CONTEXTS],
    input  pic_pkg::pri_t     prio      [pic_pkg::NUM_SOURCES],
    output pic_pkg::src_id_t  best      [pic_pkg::NUM_CONTEXTS],
    output pic_pkg::src_id_t  best_now  [pic_pkg::NUM_CONTEXTS]
);
    import pic_pkg::*;

    localparam int GRP        = 8;
    localparam int NUM_GROUPS = (NUM_SOURCES + GRP - 1) / GRP;

    typedef struct packed {
        logic    valid;
        pri_t    pri;
        src_id_t id;
    } cand_t;

    // a is the lower id: it keeps the slot on a tie
    function automatic cand_t pick(input cand_t a, input cand_t b);
        return (b.valid && (!a.valid || b.pri > a.pri)) ? b : a;
    endfunction

    cand_t grp_next [NUM_CONTEXTS][NUM_GROUPS];
    cand_t grp_reg  [NUM_CONTEXTS][NUM_GROUPS];
    src_id_t best_reg [NUM_CONTEXTS];

    always_comb begin
        cand_t acc;
        cand_t leaf;
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                acc = '0;
                for (int k = 0; k < GRP; k++) begin
                    if (g * GRP + k < NUM_SOURCES) begin
                        leaf.valid = pending[g*GRP+k] && enable[c][g*GRP+k] &&
                                     (prio[g*GRP+k] > threshold[c]);
                        leaf.pri   = prio[g*GRP+k];
                        leaf.id    = ID_W'(g * GRP + k);
                        acc        = pick(acc, leaf);
                    end
                end
                grp_next[c][g] = acc;
            end
        end
    end

    always_comb begin
        cand_t acc;
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
            acc = '0;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                acc = pick(acc, grp_reg[c][g]);
            end
            best_now[c] = acc.valid ? acc.id : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage1_en) begin
            grp_reg <= grp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                best_reg[c] <= '0;
            end
        end else if (stage2_en) begin
            best_reg <= best_now;
        end
    end

    assign best = best_reg;

endmodule

`default_nettype wire

>>> sv/pic_dp.sv
// Datapath: request latch, address decode, register file, gateways, result register.
`timescale 1ns / 1ps
`default_nettype none

module pic_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pic_pkg::pic_cmd_t            cmd,
    input  logic [pic_pkg::OP_W-1:0]     opcode,
    input  logic [pic_pkg::ADDR_W-1:0]   address,
    input  logic [pic_pkg::DATA_W-1:0]   write_data,
    input  logic [pic_pkg::LINES_W-1:0]  source_lines,
    output logic [pic_pkg::DATA_W-1:0]   read_data,
    output logic [pic_pkg::IRQ_W-1:0]    irq_out,
    output logic                         access_error
);
    import pic_pkg::*;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_PRIO,
        ACC_PEND,
        ACC_EN,
        ACC_THR,
        ACC_CLAIM,
        ACC_ERR
    } acc_t;

    // latched request
    op_t                op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [DATA_W-1:0]  wdata_reg;
    src_vec_t           lines_reg;

    // controller state
    pri_t     prio_reg [NUM_SOURCES];
    src_vec_t pending_reg;
    src_vec_t in_service_reg;
    src_vec_t en_reg  [NUM_CONTEXTS];
    pri_t     thr_reg [NUM_CONTEXTS];

    logic [DATA_W-1:0] rd_reg;
    logic              err_reg;

    logic [DATA_W-1:0] out_rd_reg;
    logic [IRQ_W-1:0]  out_irq_reg;
    logic              out_err_reg;

    src_id_t best     [NUM_CONTEXTS];
    src_id_t best_now [NUM_CONTEXTS];

    acc_t               acc;
    src_id_t            id_idx;
    ctx_idx_t           ctx_idx;
    logic [ADDR_W-1:0]  en_off;
    logic [13:0]        ctx_en;
    logic [8:0]         ctx_thr;
    src_id_t            claim_id;
    src_id_t            cpl_id;
    logic               cpl_ok;
    logic [IRQ_W-1:0]   irq_now;

    pic_arb u_arb (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage1_en (cmd.arb_load),
        .stage2_en (cmd.finish),
        .pending   (pending_reg),
        .enable    (en_reg),
        .threshold (thr_reg),
        .prio      (prio_reg),
        .best      (best),
        .best_now  (best_now)
    );

    // address decode
    always_comb begin
        acc     = ACC_ERR;
        id_idx  = addr_reg[ID_W+1:2];
        ctx_idx = '0;
        en_off  = addr_reg - EN_BASE;
        ctx_en  = en_off[20:7];
        ctx_thr = addr_reg[20:12];
        if (addr_reg[1:0] != 2'b00) begin
            acc = ACC_ERR;
        end else if (addr_reg < PEND_BASE) begin
            if ({1'b0, addr_reg[11:2]} >= 11'(NUM_SOURCES)) begin
                acc = ACC_ERR;
            end else if (addr_reg[11:2] == '0) begin
                acc = ACC_NONE;          // reserved source 0
            end else begin
                acc = ACC_PRIO;
            end
        end else if (addr_reg < EN_BASE) begin
            acc = (addr_reg[11:2] == '0) ? ACC_PEND : ACC_ERR;
        end else if (addr_reg < CTX_BASE) begin
            ctx_idx = ctx_en[CTX_W-1:0];
            if (ctx_en < 14'(NUM_CONTEXTS) && en_off[6:2] == '0) begin
                acc = ACC_EN;
            end
        end else begin
            ctx_idx = ctx_thr[CTX_W-1:0];
            if (ctx_thr < 9'(NUM_CONTEXTS)) begin
                if (addr_reg[11:0] == THR_OFF) begin
                    acc = ACC_THR;
                end else if (addr_reg[11:0] == CLAIM_OFF) begin
                    acc = ACC_CLAIM;
                end
            end
        end
    end

    assign claim_id = best[ctx_idx];
    assign cpl_id   = wdata_reg[ID_W-1:0];
    assign cpl_ok   = (wdata_reg != '0) && (wdata_reg < DATA_W'(NUM_SOURCES)) &&
                      en_reg[ctx_idx][cpl_id];

    always_comb begin
        irq_now = '0;
        for (int c = 0; c < IRQ_W; c++) begin
            if (c < NUM_CONTEXTS) begin
                irq_now[c] = (best_now[c] != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= op_t'(opcode);
            addr_reg  <= address;
            wdata_reg <= write_data;
            lines_reg <= source_lines[NUM_SOURCES-1:0];
        end
        if (cmd.finish) begin
            out_rd_reg  <= rd_reg;
            out_irq_reg <= irq_now;
            out_err_reg <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                prio_reg[i] <= '0;
            end
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                en_reg[c]  <= '0;
                thr_reg[c] <= '0;
            end
            pending_reg    <= '0;
            in_service_reg <= '0;
            rd_reg         <= '0;
            err_reg        <= 1'b0;
        end else if (cmd.execute) begin
            rd_reg  <= '0;
            err_reg <= 1'b0;
            unique case (op_reg)
                OP_SAMPLE: begin
                    // gateway: a source in service cannot raise a new request
                    pending_reg <= pending_reg | (lines_reg & SRC_MASK & ~in_service_reg);
                end
                OP_READ: begin
                    unique case (acc)
                        ACC_PRIO:  rd_reg <= DATA_W'(prio_reg[id_idx]);
                        ACC_PEND:  rd_reg <= DATA_W'(pending_reg);
                        ACC_EN:    rd_reg <= DATA_W'(en_reg[ctx_idx]);
                        ACC_THR:   rd_reg <= DATA_W'(thr_reg[ctx_idx]);
                        ACC_CLAIM: begin
                            rd_reg <= DATA_W'(claim_id);
                            if (claim_id != '0) begin
                                pending_reg[claim_id]    <= 1'b0;
                                in_service_reg[claim_id] <= 1'b1;
                            end
                        end
                        ACC_ERR:   err_reg <= 1'b1;
                        ACC_NONE:  ;
                        default:   ;
                    endcase
                end
                OP_WRITE: begin
                    unique case (acc)
                        ACC_PRIO:  prio_reg[id_idx] <= wdata_reg[PRIORITY_WIDTH-1:0];
                        ACC_EN:    en_reg[ctx_idx]  <= wdata_reg[NUM_SOURCES-1:0] & SRC_MASK;
                        ACC_THR:   thr_reg[ctx_idx] <= wdata_reg[PRIORITY_WIDTH-1:0];
                        ACC_CLAIM: begin
                            // completion
                            if (cpl_ok) begin
                                in_service_reg[cpl_id] <= 1'b0;
                            end
                        end
                        ACC_ERR:   err_reg <= 1'b1;
                        ACC_PEND:  ;     // pending word is read only
                        ACC_NONE:  ;
                        default:   ;
                    endcase
                end
                OP_IDLE: ;
            endcase
        end
    end

    assign read_data    = out_rd_reg;
    assign irq_out      = out_irq_reg;
    assign access_error = out_err_reg;

endmodule

`default_nettype wire

>>> sv/platform_interrupt_controller.sv
// Top level of the platform interrupt controller: sequencer plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Ports                Contents (low bit first)
// s_axis   in   tvalid/tready/tdata  address[21:0], write_data[53:22], source_lines[85:54]
//               tuser                opcode[1:0]
// m_axis   out  tvalid/tready/tdata  read_data[31:0], irq_out[33:32]
//               tuser                access_error[0]
//
// Each request passes through accept, execute, then two stages of the
// priority tree (8-source groups, then the group winners) that refresh the
// per-context best source and produce irq_out for the result.
// A new request is taken while a finished result still waits on m_axis; the
// final step holds only when the result register is still occupied.
// Reset (aresetn low, synchronous) clears all priorities, enables,
// thresholds, pending and in-service bits directly; no clearing pass.
// Claims use the best source computed at the end of the previous request.

module platform_interrupt_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // address[21:0], write_data[53:22], source_lines[85:54], zero pad
    input  logic [pic_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // opcode[1:0]
    input  logic [pic_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data[31:0], irq_out[33:32], zero pad
    output logic [pic_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // access_error[0]
    output logic [0:0]                      m_axis_tuser
);
    import pic_pkg::*;

    pic_cmd_t          cmd;
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_out;
    logic              access_error;

    pic_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    pic_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .opcode       (s_axis_tuser),
        .address      (s_axis_tdata[ADDR_W-1:0]),
        .write_data   (s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W]),
        .source_lines (s_axis_tdata[ADDR_W+DATA_W+LINES_W-1:ADDR_W+DATA_W]),
        .read_data    (read_data),
        .irq_out      (irq_out),
        .access_error (access_error)
    );

    assign m_axis_tdata = {{(M_TDATA_W-DATA_W-IRQ_W){1'b0}}, irq_out, read_data};
    assign m_axis_tuser = access_error;

endmodule

`default_nettype wire

>>> verif/tb_platform_interrupt_controller.sv
// Self-checking testbench of the platform interrupt controller: directed and random requests.
`timescale 1ns / 1ps

module tb_platform_interrupt_controller;
    import pic_pkg::*;

    localparam int          SRC_WORDS   = (NUM_SOURCES + 31) / 32;
    localparam logic [21:0] EN_STRIDE   = 22'h000080;
    localparam logic [21:0] CTX_STRIDE  = 22'h001000;
    localparam int          RAND_ITEMS  = 800;
    localparam int          STALL_LIMIT = 2000;   // cycles with no handshake on either side
    localparam int          DRAIN_WAIT  = 16;     // extra wait once no result is owed
    localparam bit          CHK         = 1'b1;   // result typed in the row
    localparam bit          PRED        = 1'b0;   // result taken from the predictor

    // One result: read_data, irq_out, access_error
    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic [IRQ_W-1:0]  irq;
        logic              err;
    } pic_resp_t;

    // One request plus, for typed rows, the result read straight off the spec
    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  wdata;
        logic [LINES_W-1:0] lines;
        bit                 typed;
        pic_resp_t          want;
    } pic_req_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    platform_interrupt_controller DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller state as the testbench tracks it
    // ------------------------------------------------------------------
    pri_t     src_pri [NUM_SOURCES];
    src_vec_t pend_v  = '0;
    src_vec_t busy_v  = '0;                // claimed, waiting for complete
    src_vec_t en_v    [NUM_CONTEXTS];
    pri_t     thr_v   [NUM_CONTEXTS];

    pic_resp_t resp_due_q [$];             // results owed by the block, oldest first
    int        fail_count  = 0;
    int        n_sent      = 0;
    int        n_checked   = 0;
    int        n_granted   = 0;
    int        n_bus_err   = 0;
    int        idle_cycles = 0;

    initial begin
        for (int i = 0; i < NUM_SOURCES; i++) src_pri[i] = '0;
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
            en_v[c]  = '0;
            thr_v[c] = '0;
        end
    end

    // Highest-priority pending enabled source strictly above threshold, lowest id on tie
    function automatic int top_claim(int ctx);
        int   best;
        pri_t best_pri;
        best     = 0;
        best_pri = thr_v[ctx];
        for (int id = 1; id < NUM_SOURCES; id++) begin
            if (pend_v[id] && en_v[ctx][id] && src_pri[id] > best_pri) begin
                best     = id;
                best_pri = src_pri[id];
            end
        end
        return best;
    endfunction

    // Register window access; returns 0 when the offset is unmapped or unaligned
    function automatic logic bus_access(logic wr, logic [ADDR_W-1:0] addr,
                                        logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rd);
        logic [ADDR_W-1:0] off;
        int ctx;
        int w;
        int rg;
        int id;
        rd = '0;
        if (addr[1:0] != 2'b00) return 1'b0;
        if (addr < PEND_BASE) begin
            id = int'(addr >> 2);
            if (id >= NUM_SOURCES) return 1'b0;
            if (id == 0) return 1'b1;          // reserved source: reads zero, writes dropped
            if (wr) src_pri[id] = data[PRIORITY_WIDTH-1:0];
            else rd = DATA_W'(src_pri[id]);
            return 1'b1;
        end
        if (addr < EN_BASE) begin
            w = int'((addr - PEND_BASE) >> 2);
            if (w >= SRC_WORDS) return 1'b0;
            if (!wr) rd = pend_v;              // read only, writes dropped
            return 1'b1;
        end
        if (addr < CTX_BASE) begin
            off = addr - EN_BASE;
            ctx = int'(off / EN_STRIDE);
            w   = int'((off % EN_STRIDE) >> 2);
            if (ctx >= NUM_CONTEXTS || w >= SRC_WORDS) return 1'b0;
            if (wr) en_v[ctx] = data & SRC_MASK;
            else rd = en_v[ctx];
            return 1'b1;
        end
        off = addr - CTX_BASE;
        ctx = int'(off / CTX_STRIDE);
        rg  = int'(off % CTX_STRIDE);
        if (ctx >= NUM_CONTEXTS) return 1'b0;
        if (rg == THR_OFF) begin
            if (wr) thr_v[ctx] = data[PRIORITY_WIDTH-1:0];
            else rd = DATA_W'(thr_v[ctx]);
            return 1'b1;
        end
        if (rg != CLAIM_OFF) return 1'b0;
        if (wr) begin
            // complete: only ids in range and enabled for this context
            if (data >= 1 && data < NUM_SOURCES && en_v[ctx][data[ID_W-1:0]])
                busy_v[data[ID_W-1:0]] = 1'b0;
        end else begin
            id = top_claim(ctx);
            if (id != 0) begin
                pend_v[id] = 1'b0;
                busy_v[id] = 1'b1;
                n_granted++;
            end
            rd = DATA_W'(id);
        end
        return 1'b1;
    endfunction

    // Update the tracked state for one accepted request and return its result
    function automatic pic_resp_t apply_request(pic_req_t r);
        pic_resp_t        o;
        logic [DATA_W-1:0] rd;
        o = '0;
        case (r.op)
            OP_READ, OP_WRITE: begin
                if (bus_access(r.op == OP_WRITE, r.addr, r.wdata, rd)) begin
                    o.rd = rd;
                end else begin
                    o.err = 1'b1;
                    n_bus_err++;
                end
            end
            OP_SAMPLE: begin
                // gateway: level lines set pending unless the source is in service
                pend_v = pend_v | (r.lines & SRC_MASK & ~busy_v);
            end
            default: begin
            end
        endcase
        for (int c = 0; c < NUM_CONTEXTS && c < IRQ_W; c++)
            o.irq[c] = (top_claim(c) != 0);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Random requests: mostly well-formed setup, sample, claim and complete
    // traffic on the tracked state, with some noise and broken accesses
    // ------------------------------------------------------------------
    function automatic pic_req_t random_request();
        pic_req_t r;
        int       pick;
        int       ctx;
        int       id;
        r       = '0;
        r.op    = OP_READ;
        r.addr  = ADDR_W'($urandom);   // unused fields still carry random bits
        r.wdata = $urandom;
        r.lines = $urandom;
        ctx     = $urandom_range(0, NUM_CONTEXTS - 1);
        pick    = $urandom_range(0, 99);
        if (pick < 18) begin
            r.op = OP_SAMPLE;
            if ($urandom_range(0, 1)) r.lines = $urandom & $urandom;
        end else if (pick < 28) begin
            r.op   = OP_WRITE;
            r.addr = ADDR_W'($urandom_range(0, NUM_SOURCES - 1)) << 2;
        end else if (pick < 36) begin
            r.op   = OP_WRITE;
            r.addr = EN_BASE + EN_STRIDE * ADDR_W'(ctx);
        end else if (pick < 42) begin
            r.op   = OP_WRITE;
            r.addr = CTX_BASE + CTX_STRIDE * ADDR_W'(ctx) + ADDR_W'(THR_OFF);
            if ($urandom_range(0, 3) != 0)
                r.wdata[PRIORITY_WIDTH-1:0] = PRIORITY_WIDTH'($urandom_range(0, 3));
        end else if (pick < 60) begin
            r.op   = OP_READ;
            r.addr = CTX_BASE + CTX_STRIDE * ADDR_W'(ctx) + ADDR_W'(CLAIM_OFF);
        end else if (pick < 72) begin
            // complete: usually a source that is in service, else any id
            r.op   = OP_WRITE;
            r.addr = CTX_BASE + CTX_STRIDE * ADDR_W'(ctx) + ADDR_W'(CLAIM_OFF);
            id     = $urandom_range(0, NUM_SOURCES - 1);
            for (int k = 0; k < NUM_SOURCES && !busy_v[id]; k++)
                id = (id + 1) % NUM_SOURCES;
            if (busy_v[id] && $urandom_range(0, 7) != 0) r.wdata = DATA_W'(id);
            else if ($urandom_range(0, 1)) r.wdata = $urandom_range(0, 40);
        end else if (pick < 82) begin
            r.op = OP_READ;
            case ($urandom_range(0, 3))
                0:       r.addr = ADDR_W'($urandom_range(0, NUM_SOURCES - 1)) << 2;
                1:       r.addr = PEND_BASE;
                2:       r.addr = EN_BASE + EN_STRIDE * ADDR_W'(ctx);
                default: r.addr = CTX_BASE + CTX_STRIDE * ADDR_W'(ctx);
            endcase
        end else if (pick < 88) begin
            r.op = OP_IDLE;
        end else if (pick < 94) begin
            r.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        end else begin
            // near misses: misaligned, one past the last context or word
            r.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
            case ($urandom_range(0, 3))
                0:       r.addr = (ADDR_W'($urandom_range(0, 40)) << 2) | ADDR_W'($urandom_range(1, 3));
                1:       r.addr = EN_BASE + EN_STRIDE * ADDR_W'(NUM_CONTEXTS)
                                  + ADDR_W'($urandom_range(0, 31) << 2);
                2:       r.addr = CTX_BASE + CTX_STRIDE * ADDR_W'($urandom_range(0, NUM_CONTEXTS))
                                  + ADDR_W'($urandom_range(2, 1023) << 2);
                default: r.addr = PEND_BASE + ADDR_W'($urandom_range(1, 1023) << 2);
            endcase
        end
        return r;
    endfunction

    // Directed rows: reset values, field extremes, every operation, each corner
    pic_req_t dir_tbl [$] = '{
        // after reset: priority zero, claim finds nothing
        '{OP_READ,   22'h000004, 32'h0, 32'h0, CHK, '{32'h0, 2'b00, 1'b0}},
        '{OP_READ,   CTX_BASE + CLAIM_OFF, 32'h0, 32'h0, CHK, '{32'h0, 2'b00, 1'b0}},
        // priority write keeps the low bits only
        '{OP_WRITE,  22'h000004, 32'hFFFFFFFF, 32'h0, CHK, '{32'h0, 2'b00, 1'b0}},
        '{OP_READ,   22'h000004, 32'h0, 32'h0, CHK, '{32'h7, 2'b00, 1'b0}},
        '{OP_WRITE,  22'h00007C, 32'h00000003, 32'h0, CHK, '{32'h0, 2'b00, 1'b0}},
        // reserved source 0: no error, write dropped
        '{OP_WRITE,  22'h000000, 32'hFFFFFFFF, 32'h0, CHK, '{32'h0, 2'b00, 1'b0}},
        '{OP_READ,   22'h000000, 32'h0, 32'h0, CHK, '{32'h0, 2'b00, 1'b0}},
        // unaligned and unmapped offsets
        '{OP_READ,   22'h000005, 32'h0, 32'h0, CHK, '{32'h0, 2'b00, 1'b1}},
        '{OP_WRITE,  22'h200002, 32'hFFFFFFFF, 32'h0, CHK, '{32'h0, 2'b00, 1'b1}},
        '{OP_READ,   22'h000080, 32'h0, 32'h0, CHK, '{32'h0, 2'b00, 1'b1}},
        '{OP_READ,   PEND_BASE + 22'h4, 32'h0, 32'h0, CHK, '{32'h0, 2'b00, 1'b1}},
        '{OP_WRITE,  EN_BASE + 22'd2 * EN_STRIDE, 32'hFFFFFFFF, 32'h0, CHK, '{32'h0, 2'b00, 1'b1}},
        '{OP_READ,   EN_BASE + 22'h4, 32'h0, 32'h0, CHK, '{32'h0, 2'b00, 1'b1}},
        '{OP_WRITE,  CTX_BASE + 22'h8, 32'h0, 32'h0, CHK, '{32'h0, 2'b00, 1'b1}},
        '{OP_READ,   CTX_BASE + 22'd2 * CTX_STRIDE, 32'h0, 32'h0, CHK, '{32'h0, 2'b00, 1'b1}},
        '{OP_WRITE,  22'h3FFFFC, 32'hFFFFFFFF, 32'h0, CHK, '{32'h0, 2'b00, 1'b1}},
        // idle opcode with every field at its top
        '{OP_IDLE,   22'h3FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, CHK, '{32'h0, 2'b00, 1'b0}},
        // pending word is read only; enables, sample, claim, complete
        '{OP_WRITE,  PEND_BASE, 32'hFFFFFFFF, 32'h0, PRED, '0},
        '{OP_WRITE,  EN_BASE, 32'hFFFFFFFF, 32'h0, PRED, '0},
        '{OP_READ,   EN_BASE, 32'h0, 32'h0, PRED, '0},
        '{OP_WRITE,  EN_BASE + EN_STRIDE, 32'h80000003, 32'h0, PRED, '0},
        '{OP_SAMPLE, 22'h0, 32'h0, 32'hFFFFFFFF, PRED, '0},
        '{OP_READ,   PEND_BASE, 32'h0, 32'h0, PRED, '0},
        '{OP_WRITE,  CTX_BASE + CTX_STRIDE, 32'hFFFFFFFF, 32'h0, PRED, '0},
        '{OP_READ,   CTX_BASE + CLAIM_OFF, 32'h0, 32'h0, PRED, '0},
        // source in service is not pended again until completed
        '{OP_SAMPLE, 22'h0, 32'h0, 32'hFFFFFFFF, PRED, '0},
        '{OP_WRITE,  CTX_BASE + CTX_STRIDE + CLAIM_OFF, 32'h00000020, 32'h0, PRED, '0},
        '{OP_WRITE,  CTX_BASE + CLAIM_OFF, 32'h00000001, 32'h0, PRED, '0},
        '{OP_SAMPLE, 22'h0, 32'h0, 32'h00000002, PRED, '0},
        '{OP_READ,   CTX_BASE + CTX_STRIDE + CLAIM_OFF, 32'h0, 32'h0, PRED, '0},
        '{OP_READ,   CTX_BASE + CTX_STRIDE, 32'h0, 32'h0, PRED, '0}
    };

    // Present one request and hold it until taken; the result is worked out on acceptance
    task automatic push_request(input pic_req_t r);
        pic_resp_t p;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.lines, r.wdata, r.addr};
        s_axis_tuser  <= r.op;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        p = apply_request(r);
        resp_due_q.push_back(r.typed ? r.want : p);
        n_sent++;
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of requests with random gaps
    // ------------------------------------------------------------------
    initial begin
        pic_req_t r;
        int       burst_left;
        int       total;
        burst_left = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        total = dir_tbl.size() + RAND_ITEMS;
        for (int n = 0; n < total; n++) begin
            r = (n < dir_tbl.size()) ? dir_tbl[n] : random_request();
            if (burst_left == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                // mostly short bursts, now and then a long back-to-back stretch
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
            push_request(r);
        end
        s_axis_tvalid <= 1'b0;
        while (resp_due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (resp_due_q.size() != 0) begin
            $error("%0d results never arrived", resp_due_q.size());
            fail_count++;
        end
        $display("Covered %0d requests (%0d directed, %0d random), %0d results compared.",
                 n_sent, dir_tbl.size(), RAND_ITEMS, n_checked);
        $display("Claims granted: %0d, bus accesses flagged as errors: %0d.",
                 n_granted, n_bus_err);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches at rx_cycle[5:0] wraps between always
    // ready, coin flip, one cycle in four, and runs of up to 10 stalls
    // ------------------------------------------------------------------
    logic [7:0] rx_cycle = '0;
    logic [1:0] rx_mode  = '0;
    int         rx_hold  = 0;

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (rx_cycle[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (rx_cycle[1:0] == 2'b11);
            default: begin
                if (rx_hold != 0) begin
                    rx_hold       <= rx_hold - 1;
                    m_axis_tready <= 1'b0;
                end else begin
                    rx_hold       <= $urandom_range(0, 10);
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pic_resp_t got;
        pic_resp_t want;
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.rd  = m_axis_tdata[31:0];
            got.irq = m_axis_tdata[33:32];
            got.err = m_axis_tuser[0];
            if (resp_due_q.size() == 0) begin
                $error("result with none outstanding: read_data %h irq_out %b access_error %b",
                       got.rd, got.irq, got.err);
                fail_count++;
            end else begin
                want = resp_due_q.pop_front();
                n_checked++;
                if (got.rd !== want.rd) begin
                    $error("read_data: expected %h, actual %h", want.rd, got.rd);
                    fail_count++;
                end
                if (got.irq !== want.irq) begin
                    $error("irq_out: expected %b, actual %b", want.irq, got.irq);
                    fail_count++;
                end
                if (got.err !== want.err) begin
                    $error("access_error: expected %b, actual %b", want.err, got.err);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: no handshake on either side for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready === 1'b1)
                     || (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("No handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, resp_due_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
